FILE: design/omd_pkg.sv
// ----------------------------------------------------------------------------
// omd_pkg: shared types and constants of the opcode message deframer
// Phase codes, message and field kind codes, opcode values and the result
// record passed from the parser to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package omd_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HDR,
    PH_VIS,
    PH_POSTER,
    PH_CONTENT,
    PH_ACKSUB,
    PH_COUNT,
    PH_NAMES,
    PH_POSTS,
    PH_FOLLOWERS,
    PH_FOLLOWING,
    PH_ERRSUB,
    PH_DEAD
  } phase_t;

  // Message kind codes
  localparam logic [2:0] MK_PENDING = 3'd0;
  localparam logic [2:0] MK_NOTIFY  = 3'd1;
  localparam logic [2:0] MK_ACK     = 3'd2;
  localparam logic [2:0] MK_ERROR   = 3'd3;
  localparam logic [2:0] MK_UNKNOWN = 3'd4;

  // Field kind codes
  localparam logic [3:0] FK_PARTIAL      = 4'd0;
  localparam logic [3:0] FK_OPCODE       = 4'd1;
  localparam logic [3:0] FK_ACK_SUBJECT  = 4'd2;
  localparam logic [3:0] FK_ERR_SUBJECT  = 4'd3;
  localparam logic [3:0] FK_COUNT        = 4'd4;
  localparam logic [3:0] FK_NAME_CHAR    = 4'd5;
  localparam logic [3:0] FK_NAME_END     = 4'd6;
  localparam logic [3:0] FK_VISIBILITY   = 4'd7;
  localparam logic [3:0] FK_POSTER_CHAR  = 4'd8;
  localparam logic [3:0] FK_POSTER_END   = 4'd9;
  localparam logic [3:0] FK_CONTENT_CHAR = 4'd10;
  localparam logic [3:0] FK_CONTENT_END  = 4'd11;
  localparam logic [3:0] FK_POSTS        = 4'd12;
  localparam logic [3:0] FK_FOLLOWERS    = 4'd13;
  localparam logic [3:0] FK_FOLLOWING    = 4'd14;
  localparam logic [3:0] FK_IGNORED      = 4'd15;

  // Opcodes and acknowledgement subjects
  localparam logic [15:0] OP_NOTIFY      = 16'd9;
  localparam logic [15:0] OP_ACK         = 16'd10;
  localparam logic [15:0] OP_ERROR       = 16'd11;
  localparam logic [15:0] SUB_LIST_A     = 16'd4;
  localparam logic [15:0] SUB_LIST_B     = 16'd7;
  localparam logic [15:0] SUB_STATS      = 16'd8;

  localparam logic [7:0]  NUL_CHAR       = 8'h00;

  // One result item
  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [3:0]  field_kind;
    logic [15:0] field_value;
    logic        message_done;
  } result_t;

endpackage

`default_nettype wire

FILE: design/omd_chan_if.sv
// ----------------------------------------------------------------------------
// omd_chan_if: byte and result channels of the deframer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface omd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface omd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  msg_kind;
  logic [3:0]  field_kind;
  logic [15:0] field_value;
  logic        message_done;

  modport source (output valid, output msg_kind, output field_kind,
                  output field_value, output message_done, input ready);
  modport sink   (input valid, input msg_kind, input field_kind,
                  input field_value, input message_done, output ready);
endinterface

`default_nettype wire

FILE: design/omd_parser.sv
// ----------------------------------------------------------------------------
// omd_parser: message framing state machine
// Decodes one byte per enabled cycle against the current phase, gives the
// result for that byte and updates the framing state.
// ----------------------------------------------------------------------------
`default_nettype none

module omd_parser
  import omd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output result_t         result
);

  phase_t      phase, phase_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held, held_next;
  logic [2:0]  kind, kind_next;
  logic [14:0] names_expected, names_expected_next;
  logic [14:0] names_seen, names_seen_next;

  logic        short_full;
  logic [15:0] short_val;
  logic [15:0] count_val;
  logic [14:0] seen_inc;
  logic        short_phase;

  function automatic logic [2:0] kind_of(input logic [15:0] op);
    logic [2:0] k;
    k = MK_UNKNOWN;
    if (op == OP_NOTIFY) k = MK_NOTIFY;
    else if (op == OP_ACK) k = MK_ACK;
    else if (op == OP_ERROR) k = MK_ERROR;
    return k;
  endfunction

  // Big-endian short assembly
  assign short_full = held;
  assign short_val  = {held_byte, rx_byte};
  assign count_val  = short_val[15] ? 16'd0 : short_val;
  assign seen_inc   = names_seen + 15'd1;

  always_comb begin
    case (phase)
      PH_HDR, PH_ACKSUB, PH_COUNT, PH_POSTS,
      PH_FOLLOWERS, PH_FOLLOWING, PH_ERRSUB: short_phase = 1'b1;
      default:                               short_phase = 1'b0;
    endcase
  end

  // Result for the current byte
  always_comb begin
    result.msg_kind     = kind;
    result.field_kind   = FK_PARTIAL;
    result.field_value  = 16'd0;
    result.message_done = 1'b0;
    case (phase)
      PH_HDR: begin
        if (!short_full) begin
          result.msg_kind = MK_PENDING;
        end else begin
          result.msg_kind    = kind_of(short_val);
          result.field_kind  = FK_OPCODE;
          result.field_value = short_val;
        end
      end
      PH_VIS: begin
        result.field_kind  = FK_VISIBILITY;
        result.field_value = {8'd0, rx_byte};
      end
      PH_POSTER: begin
        if (rx_byte != NUL_CHAR) begin
          result.field_kind  = FK_POSTER_CHAR;
          result.field_value = {8'd0, rx_byte};
        end else begin
          result.field_kind = FK_POSTER_END;
        end
      end
      PH_CONTENT: begin
        if (rx_byte != NUL_CHAR) begin
          result.field_kind  = FK_CONTENT_CHAR;
          result.field_value = {8'd0, rx_byte};
        end else begin
          result.field_kind   = FK_CONTENT_END;
          result.message_done = 1'b1;
        end
      end
      PH_ACKSUB: begin
        if (short_full) begin
          result.field_kind   = FK_ACK_SUBJECT;
          result.field_value  = short_val;
          result.message_done = (short_val != SUB_LIST_A) && (short_val != SUB_LIST_B)
                                && (short_val != SUB_STATS);
        end
      end
      PH_COUNT: begin
        if (short_full) begin
          result.field_kind  = FK_COUNT;
          result.field_value = count_val;
        end
      end
      PH_NAMES: begin
        if (names_seen < names_expected) begin
          if (rx_byte != NUL_CHAR) begin
            result.field_kind  = FK_NAME_CHAR;
            result.field_value = {8'd0, rx_byte};
          end else begin
            result.field_kind   = FK_NAME_END;
            result.message_done = (seen_inc == names_expected);
          end
        end else begin
          // zero count: the byte after the count closes the message
          result.field_kind   = FK_IGNORED;
          result.message_done = 1'b1;
        end
      end
      PH_POSTS: begin
        if (short_full) begin
          result.field_kind  = FK_POSTS;
          result.field_value = short_val;
        end
      end
      PH_FOLLOWERS: begin
        if (short_full) begin
          result.field_kind  = FK_FOLLOWERS;
          result.field_value = short_val;
        end
      end
      PH_FOLLOWING: begin
        if (short_full) begin
          result.field_kind   = FK_FOLLOWING;
          result.field_value  = short_val;
          result.message_done = 1'b1;
        end
      end
      PH_ERRSUB: begin
        if (short_full) begin
          result.field_kind   = FK_ERR_SUBJECT;
          result.field_value  = short_val;
          result.message_done = 1'b1;
        end
      end
      default: begin
        result.msg_kind   = MK_UNKNOWN;
        result.field_kind = FK_IGNORED;
      end
    endcase
  end

  // Next framing state
  always_comb begin
    phase_next          = phase;
    held_byte_next      = held_byte;
    held_next           = held;
    kind_next           = kind;
    names_expected_next = names_expected;
    names_seen_next     = names_seen;

    if (short_phase) begin
      if (!short_full) begin
        held_byte_next = rx_byte;
        held_next      = 1'b1;
      end else begin
        held_byte_next = 8'd0;
        held_next      = 1'b0;
      end
    end

    case (phase)
      PH_HDR: begin
        if (short_full) begin
          kind_next = kind_of(short_val);
          case (short_val)
            OP_NOTIFY: phase_next = PH_VIS;
            OP_ACK:    phase_next = PH_ACKSUB;
            OP_ERROR:  phase_next = PH_ERRSUB;
            default:   phase_next = PH_DEAD;
          endcase
        end
      end
      PH_VIS:    phase_next = PH_POSTER;
      PH_POSTER: if (rx_byte == NUL_CHAR) phase_next = PH_CONTENT;
      PH_ACKSUB: begin
        if (short_full) begin
          if (short_val == SUB_LIST_A || short_val == SUB_LIST_B) phase_next = PH_COUNT;
          else if (short_val == SUB_STATS) phase_next = PH_POSTS;
        end
      end
      PH_COUNT: begin
        if (short_full) begin
          names_expected_next = count_val[14:0];
          names_seen_next     = 15'd0;
          phase_next          = PH_NAMES;
        end
      end
      PH_NAMES: begin
        if (names_seen < names_expected && rx_byte == NUL_CHAR) names_seen_next = seen_inc;
      end
      PH_POSTS:     if (short_full) phase_next = PH_FOLLOWERS;
      PH_FOLLOWERS: if (short_full) phase_next = PH_FOLLOWING;
      PH_CONTENT, PH_FOLLOWING, PH_ERRSUB: ;
      default: begin
        phase_next = PH_DEAD;
        kind_next  = MK_UNKNOWN;
      end
    endcase

    // end of message: back to the header
    if (result.message_done) begin
      phase_next     = PH_HDR;
      held_byte_next = 8'd0;
      held_next      = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR;
      held_byte      <= 8'd0;
      held           <= 1'b0;
      kind           <= MK_UNKNOWN;
      names_expected <= 15'd0;
      names_seen     <= 15'd0;
    end else if (step) begin
      phase          <= phase_next;
      held_byte      <= held_byte_next;
      held           <= held_next;
      kind           <= kind_next;
      names_expected <= names_expected_next;
      names_seen     <= names_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/opcode_message_byte_deframer.sv
// ----------------------------------------------------------------------------
// opcode_message_byte_deframer: server message byte deframer
// Registers each received byte, decodes it against the framing state and
// registers one result item per byte.
//
//   channel       dir  payload                                         items
//   byte_chan     in   rx_byte[7:0]                                    1/byte
//   result_chan   out  msg_kind, field_kind, field_value, message_done 1/byte
//
// One byte a cycle sustained while the result channel is ready; each byte passes
// the byte register, then the result register. The rate is set by the single framing state update done per byte.
// rst (synchronous) empties both register stages and returns to the header.
// A stalled result holds in the output register; the byte register still
// takes one more byte while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module opcode_message_byte_deframer
  import omd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  omd_byte_if.sink      byte_chan,
  omd_result_if.source  result_chan
);

  logic       byte_vld;
  logic [7:0] byte_reg;
  logic       res_vld;
  result_t    res_reg;
  result_t    step_res;
  logic       res_free;
  logic       advance;

  // Stage handshake
  assign res_free       = !res_vld || result_chan.ready;
  assign advance        = byte_vld && res_free;
  assign byte_chan.ready = !byte_vld || advance;

  // Input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (byte_chan.ready) begin
      byte_vld <= byte_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_chan.valid && byte_chan.ready) begin
      byte_reg <= byte_chan.rx_byte;
    end
  end

  omd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (byte_reg),
    .result  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (res_free) begin
      res_vld <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= step_res;
    end
  end

  assign result_chan.valid        = res_vld;
  assign result_chan.msg_kind     = res_reg.msg_kind;
  assign result_chan.field_kind   = res_reg.field_kind;
  assign result_chan.field_value  = res_reg.field_value;
  assign result_chan.message_done = res_reg.message_done;

  // Checks
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    byte_vld && !advance |=> byte_vld && $stable(byte_reg))
    else $error("byte register lost a pending item");

  a_pending_partial: assert property (@(posedge clk) disable iff (rst)
    res_vld && res_reg.msg_kind == MK_PENDING |->
      res_reg.field_kind == FK_PARTIAL && !res_reg.message_done)
    else $error("header byte reported as complete");

  a_ignored_done: assert property (@(posedge clk) disable iff (rst)
    res_vld && res_reg.field_kind == FK_IGNORED && res_reg.message_done |->
      res_reg.msg_kind == MK_ACK)
    else $error("ignored byte closed a message other than an acknowledgement");

  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_vld)
    else $error("decoded item not held in result register");

endmodule

`default_nettype wire
